// ===== rtl/sccol_pkg.sv =====
// sccol_pkg: shared types for the swept circle collision test
// holds the result cause codes and the pipeline control group
// no dependencies
package sccol_pkg;

  // reason reported with each result item
  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_OVERLAP = 2'd1,
    CAUSE_SINGLE  = 2'd2,
    CAUSE_CROSS   = 2'd3
  } cause_t;

  // control group handed from the top level to each pipelined unit
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

// ===== rtl/swept_circle_collision_test.sv =====
// swept_circle_collision_test: pipelined overlap and tunneling test of a circle pair
// uses sccol_mul for the product stages and sccol_div for the contact quotients
// depends on sccol_pkg
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, first_*, second_*      | in item
//  out     | out_valid, out_stall, collided, contact_*, | out item
//          | cause                                      |
//
// one item enters per cycle while the output is not stalled; the quotient divider
// resolves one bit per stage over COORD_WIDTH + 2 stages
// a stalled output freezes every stage at once; the input stalls only then
// reset clears the valid bits; payload registers are not reset
module swept_circle_collision_test #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_vx,
  input  logic signed [COORD_WIDTH-1:0] first_vy,
  input  logic [COORD_WIDTH-2:0]        first_radius,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_vx,
  input  logic signed [COORD_WIDTH-1:0] second_vy,
  input  logic [COORD_WIDTH-2:0]        second_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          collided,
  output logic signed [COORD_WIDTH-1:0] contact_x,
  output logic signed [COORD_WIDTH-1:0] contact_y,
  output logic [1:0]                    cause
);

  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + 2;
  localparam int PW1 = 2 * EW;
  localparam int SW  = PW1 + 1;
  localparam int PW2 = 2 * SW;
  localparam int QB  = W + 2;
  localparam int NW  = SW + EW;
  localparam int M1L = 22;
  localparam int M2L = 4;

  typedef struct packed {
    logic               still1;
    logic               still2;
    logic signed [W-1:0]  mx;
    logic signed [W-1:0]  my;
    logic signed [EW-1:0] sdx;
    logic signed [EW-1:0] sdy;
    logic signed [W:0]    ax;
    logic signed [W:0]    ay;
    logic signed [W:0]    qx;
    logic signed [W:0]    qy;
    logic signed [EW-1:0] v1x;
    logic signed [EW-1:0] v1y;
    logic signed [W-1:0]  p1x;
    logic signed [W-1:0]  p1y;
    logic signed [W-1:0]  p2x;
    logic signed [W-1:0]  p2y;
  } sb1_t;

  typedef struct packed {
    logic               overlap;
    logic               still1;
    logic               still2;
    logic               denz;
    logic               c1ez;
    logic signed [SW-1:0] sc_lo;
    logic signed [SW-1:0] sc_hi;
    logic signed [SW-1:0] dd1;
    logic signed [SW-1:0] tn;
    logic signed [SW-1:0] un;
    logic signed [SW-1:0] den;
    logic signed [SW-1:0] denom;
    logic signed [W:0]    base_x;
    logic signed [W:0]    base_y;
    logic signed [W:0]    mid_ov_x;
    logic signed [W:0]    mid_ov_y;
    logic signed [W:0]    mid_cl_x;
    logic signed [W:0]    mid_cl_y;
  } sb3_t;

  typedef struct packed {
    sccol_pkg::cause_t  cause;
    logic               use_mid;
    logic signed [W:0]  mid_x;
    logic signed [W:0]  mid_y;
    logic signed [W:0]  base_x;
    logic signed [W:0]  base_y;
  } sb4_t;

  logic en;

  // stage 1 registers
  logic                 s1_vld;
  logic signed [EW-1:0] s1_dx, s1_dy, s1_rs, s1_swx, s1_swy, s1_sr;
  logic signed [EW-1:0] s1_ex, s1_ey, s1_v2x, s1_v2y;
  sb1_t                 s1_sb;

  // first product stage
  logic [M1L-1:0][EW-1:0]  m1_a, m1_b;
  logic [M1L-1:0][PW1-1:0] m1_p;
  logic                    m1_vld;
  sb1_t                    m1_sb;
  logic signed [PW1-1:0]   pr1 [M1L];

  // stage 2 registers
  logic                 s2_vld;
  logic signed [SW-1:0] s2_dist2, s2_rs2, s2_dd, s2_cr, s2_dot, s2_rr;
  logic signed [SW-1:0] s2_den, s2_c1e, s2_sc, s2_sd, s2_dd1, s2_tn;
  sb1_t                 s2_sb;

  // stage 3 registers
  logic                   s3_vld;
  logic [M2L-1:0][SW-1:0] s3_ma, s3_mb;
  sb3_t                   s3_sb;
  logic                   single3;
  logic                   dneg3;
  logic signed [SW-1:0]   ntn3;
  logic signed [W+1:0]    sum_ovx, sum_ovy, sum_clx, sum_cly;

  // second product stage
  logic [M2L-1:0][PW2-1:0] m2_p;
  logic                    m2_vld;
  sb3_t                    m2_sb;

  // stage 4 registers
  logic                 s4_vld;
  logic signed [NW-1:0] s4_num_x, s4_num_y;
  logic [SW-1:0]        s4_denom;
  sb4_t                 s4_sb;
  logic                 single_hit, col_ok, crs_ok, both_ok;
  logic signed [SW-1:0] lo4, hi4;
  sccol_pkg::cause_t    cause4;

  // divider outputs
  logic                 dv_vld;
  logic signed [QB:0]   quo_x, quo_y;
  sb4_t                 dv_sb;
  logic signed [W+2:0]  sum_x, sum_y;

  // the whole pipeline moves unless a finished item is held at the output
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: differences and single mover selection
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic st1, st2;
    st1 = (first_vx == '0) && (first_vy == '0);
    st2 = (second_vx == '0) && (second_vy == '0);
    if (en) begin
      s1_dx  <= EW'(first_x) - EW'(second_x);
      s1_dy  <= EW'(first_y) - EW'(second_y);
      s1_rs  <= $signed(EW'(first_radius) + EW'(second_radius));
      // a still first circle means the second one moves
      s1_swx <= st1 ? EW'(first_x) - EW'(second_x) : EW'(second_x) - EW'(first_x);
      s1_swy <= st1 ? EW'(first_y) - EW'(second_y) : EW'(second_y) - EW'(first_y);
      s1_sr  <= $signed(st1 ? EW'(first_radius) : EW'(second_radius));
      s1_ex  <= EW'(second_x) - EW'(second_vx) - EW'(first_x) + EW'(first_vx);
      s1_ey  <= EW'(second_y) - EW'(second_vy) - EW'(first_y) + EW'(first_vy);
      s1_v2x <= EW'(second_vx);
      s1_v2y <= EW'(second_vy);
      s1_sb.still1 <= st1;
      s1_sb.still2 <= st2;
      s1_sb.mx     <= st1 ? second_x : first_x;
      s1_sb.my     <= st1 ? second_y : first_y;
      s1_sb.sdx    <= st1 ? EW'(second_vx) : EW'(first_vx);
      s1_sb.sdy    <= st1 ? EW'(second_vy) : EW'(first_vy);
      s1_sb.ax     <= (W+1)'(first_x) - (W+1)'(first_vx);
      s1_sb.ay     <= (W+1)'(first_y) - (W+1)'(first_vy);
      s1_sb.qx     <= (W+1)'(second_x) - (W+1)'(second_vx);
      s1_sb.qy     <= (W+1)'(second_y) - (W+1)'(second_vy);
      s1_sb.v1x    <= EW'(first_vx);
      s1_sb.v1y    <= EW'(first_vy);
      s1_sb.p1x    <= first_x;
      s1_sb.p1y    <= first_y;
      s1_sb.p2x    <= second_x;
      s1_sb.p2y    <= second_y;
    end
  end

  // first level products: distances, single mover terms, path crossing terms
  always_comb begin
    m1_a[0]  = s1_dx;       m1_b[0]  = s1_dx;
    m1_a[1]  = s1_dy;       m1_b[1]  = s1_dy;
    m1_a[2]  = s1_rs;       m1_b[2]  = s1_rs;
    m1_a[3]  = s1_sb.sdx;   m1_b[3]  = s1_sb.sdx;
    m1_a[4]  = s1_sb.sdy;   m1_b[4]  = s1_sb.sdy;
    m1_a[5]  = s1_sb.sdx;   m1_b[5]  = s1_swy;
    m1_a[6]  = s1_sb.sdy;   m1_b[6]  = s1_swx;
    m1_a[7]  = s1_sb.sdx;   m1_b[7]  = s1_swx;
    m1_a[8]  = s1_sb.sdy;   m1_b[8]  = s1_swy;
    m1_a[9]  = s1_sr;       m1_b[9]  = s1_sr;
    m1_a[10] = s1_sb.v1x;   m1_b[10] = s1_v2y;
    m1_a[11] = s1_sb.v1y;   m1_b[11] = s1_v2x;
    m1_a[12] = s1_sb.v1x;   m1_b[12] = s1_ey;
    m1_a[13] = s1_sb.v1y;   m1_b[13] = s1_ex;
    m1_a[14] = s1_ex;       m1_b[14] = s1_sb.v1x;
    m1_a[15] = s1_ey;       m1_b[15] = s1_sb.v1y;
    m1_a[16] = s1_v2x;      m1_b[16] = s1_sb.v1x;
    m1_a[17] = s1_v2y;      m1_b[17] = s1_sb.v1y;
    m1_a[18] = s1_sb.v1x;   m1_b[18] = s1_sb.v1x;
    m1_a[19] = s1_sb.v1y;   m1_b[19] = s1_sb.v1y;
    m1_a[20] = s1_ex;       m1_b[20] = s1_v2y;
    m1_a[21] = s1_ey;       m1_b[21] = s1_v2x;
  end

  sccol_mul #(
    .LANES (M1L),
    .AW    (EW),
    .BW    (EW),
    .SBW   ($bits(sb1_t))
  ) u_mul1 (
    .clk    (clk),
    .rst    (rst),
    .ctl    ('{en: en, vld: s1_vld}),
    .a      (m1_a),
    .b      (m1_b),
    .sb_in  (s1_sb),
    .vld    (m1_vld),
    .p      (m1_p),
    .sb_out (m1_sb)
  );

  always_comb begin
    for (int k = 0; k < M1L; k++) pr1[k] = $signed(m1_p[k]);
  end

  // stage 2: dot and cross products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dist2 <= SW'(pr1[0]) + SW'(pr1[1]);
      s2_rs2   <= SW'(pr1[2]);
      s2_dd    <= SW'(pr1[3]) + SW'(pr1[4]);
      s2_cr    <= SW'(pr1[5]) - SW'(pr1[6]);
      s2_dot   <= SW'(pr1[7]) + SW'(pr1[8]);
      s2_rr    <= SW'(pr1[9]);
      s2_den   <= SW'(pr1[10]) - SW'(pr1[11]);
      s2_c1e   <= SW'(pr1[12]) - SW'(pr1[13]);
      s2_sc    <= SW'(pr1[14]) + SW'(pr1[15]);
      s2_sd    <= SW'(pr1[14]) + SW'(pr1[15]) + SW'(pr1[16]) + SW'(pr1[17]);
      s2_dd1   <= SW'(pr1[18]) + SW'(pr1[19]);
      s2_tn    <= SW'(pr1[20]) - SW'(pr1[21]);
      s2_sb    <= m1_sb;
    end
  end

  // stage 3: sign normalization, projection operands, midpoints
  assign single3 = s2_sb.still1 ^ s2_sb.still2;
  assign dneg3   = s2_den[SW-1];
  assign ntn3    = dneg3 ? -s2_tn : s2_tn;
  assign sum_ovx = (W+2)'(s2_sb.p1x) + (W+2)'(s2_sb.p2x);
  assign sum_ovy = (W+2)'(s2_sb.p1y) + (W+2)'(s2_sb.p2y);
  assign sum_clx = (W+2)'(s2_sb.p1x) + (W+2)'(s2_sb.qx);
  assign sum_cly = (W+2)'(s2_sb.p1y) + (W+2)'(s2_sb.qy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ma[0] <= s2_cr;
      s3_mb[0] <= s2_cr;
      s3_ma[1] <= s2_rr;
      s3_mb[1] <= s2_dd;
      s3_ma[2] <= single3 ? s2_dot : ntn3;
      s3_mb[2] <= single3 ? SW'(s2_sb.sdx) : SW'(s2_sb.v1x);
      s3_ma[3] <= single3 ? s2_dot : ntn3;
      s3_mb[3] <= single3 ? SW'(s2_sb.sdy) : SW'(s2_sb.v1y);
      s3_sb.overlap  <= s2_dist2 < s2_rs2;
      s3_sb.still1   <= s2_sb.still1;
      s3_sb.still2   <= s2_sb.still2;
      s3_sb.denz     <= s2_den == '0;
      s3_sb.c1ez     <= s2_c1e == '0;
      s3_sb.sc_lo    <= (s2_sc < s2_sd) ? s2_sc : s2_sd;
      s3_sb.sc_hi    <= (s2_sc < s2_sd) ? s2_sd : s2_sc;
      s3_sb.dd1      <= s2_dd1;
      s3_sb.tn       <= ntn3;
      // crossing parameter of the second path is the negated first cross
      s3_sb.un       <= dneg3 ? s2_c1e : -s2_c1e;
      s3_sb.den      <= dneg3 ? -s2_den : s2_den;
      s3_sb.denom    <= single3 ? s2_dd : (dneg3 ? -s2_den : s2_den);
      s3_sb.base_x   <= single3 ? (W+1)'(s2_sb.mx) : s2_sb.ax;
      s3_sb.base_y   <= single3 ? (W+1)'(s2_sb.my) : s2_sb.ay;
      s3_sb.mid_ov_x <= $signed(sum_ovx[W+1:1]);
      s3_sb.mid_ov_y <= $signed(sum_ovy[W+1:1]);
      s3_sb.mid_cl_x <= $signed(sum_clx[W+1:1]);
      s3_sb.mid_cl_y <= $signed(sum_cly[W+1:1]);
    end
  end

  sccol_mul #(
    .LANES (M2L),
    .AW    (SW),
    .BW    (SW),
    .SBW   ($bits(sb3_t))
  ) u_mul2 (
    .clk    (clk),
    .rst    (rst),
    .ctl    ('{en: en, vld: s3_vld}),
    .a      (s3_ma),
    .b      (s3_mb),
    .sb_in  (s3_sb),
    .vld    (m2_vld),
    .p      (m2_p),
    .sb_out (m2_sb)
  );

  // stage 4: decisions and divider operands
  assign single_hit = $signed(m2_p[0]) < $signed(m2_p[1]);
  assign lo4        = m2_sb.sc_lo[SW-1] ? '0 : m2_sb.sc_lo;
  assign hi4        = (m2_sb.sc_hi > m2_sb.dd1) ? m2_sb.dd1 : m2_sb.sc_hi;
  assign col_ok     = m2_sb.c1ez && (lo4 <= hi4);
  assign crs_ok     = !m2_sb.tn[SW-1] && (m2_sb.tn <= m2_sb.den) &&
                      !m2_sb.un[SW-1] && (m2_sb.un <= m2_sb.den);
  assign both_ok    = m2_sb.denz ? col_ok : crs_ok;

  // overlap wins, then the still pair, then one mover, then two movers
  always_comb begin
    priority if (m2_sb.overlap) begin
      cause4 = sccol_pkg::CAUSE_OVERLAP;
    end else if (m2_sb.still1 && m2_sb.still2) begin
      cause4 = sccol_pkg::CAUSE_NONE;
    end else if (m2_sb.still1 || m2_sb.still2) begin
      cause4 = single_hit ? sccol_pkg::CAUSE_SINGLE : sccol_pkg::CAUSE_NONE;
    end else begin
      cause4 = both_ok ? sccol_pkg::CAUSE_CROSS : sccol_pkg::CAUSE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_num_x       <= $signed(m2_p[2][NW-1:0]);
      s4_num_y       <= $signed(m2_p[3][NW-1:0]);
      s4_denom       <= m2_sb.denom;
      s4_sb.cause    <= cause4;
      // a still circle also zeroes the path cross, so collinear only with two movers
      s4_sb.use_mid  <= m2_sb.overlap ||
                        (m2_sb.denz && !m2_sb.still1 && !m2_sb.still2);
      s4_sb.mid_x    <= m2_sb.overlap ? m2_sb.mid_ov_x : m2_sb.mid_cl_x;
      s4_sb.mid_y    <= m2_sb.overlap ? m2_sb.mid_ov_y : m2_sb.mid_cl_y;
      s4_sb.base_x   <= m2_sb.base_x;
      s4_sb.base_y   <= m2_sb.base_y;
    end
  end

  sccol_div #(
    .NW   (NW),
    .DENW (SW),
    .QB   (QB),
    .SBW  ($bits(sb4_t))
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .ctl    ('{en: en, vld: s4_vld}),
    .num_x  (s4_num_x),
    .num_y  (s4_num_y),
    .den    (s4_denom),
    .sb_in  (s4_sb),
    .vld    (dv_vld),
    .quo_x  (quo_x),
    .quo_y  (quo_y),
    .sb_out (dv_sb)
  );

  // output stage: contact point, saturated to the coordinate range
  assign sum_x = dv_sb.use_mid ? (W+3)'(dv_sb.mid_x) : (W+3)'(dv_sb.base_x) + (W+3)'(quo_x);
  assign sum_y = dv_sb.use_mid ? (W+3)'(dv_sb.mid_y) : (W+3)'(dv_sb.base_y) + (W+3)'(quo_y);

  function automatic logic [W-1:0] sat(input logic [W+2:0] s);
    logic fits;
    fits = (&s[W+2:W-1]) || !(|s[W+2:W-1]);
    if (fits) return s[W-1:0];
    return s[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      collided  <= dv_sb.cause != sccol_pkg::CAUSE_NONE;
      cause     <= dv_sb.cause;
      contact_x <= (dv_sb.cause != sccol_pkg::CAUSE_NONE) ? $signed(sat(sum_x)) : '0;
      contact_y <= (dv_sb.cause != sccol_pkg::CAUSE_NONE) ? $signed(sat(sum_y)) : '0;
    end
  end

  // checks
  a_collided_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (collided == (cause != sccol_pkg::CAUSE_NONE)))
    else $error("collided flag disagrees with cause");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !collided) |-> (contact_x == '0 && contact_y == '0))
    else $error("contact not zero on a miss");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output");

endmodule

// ===== rtl/sccol_mul.sv =====
// sccol_mul: lanes of signed multipliers, two register stages
// each operand is split into halves; partial products, then their sum
// depends on sccol_pkg (pipe_ctl_t)
module sccol_mul #(
  parameter int LANES = 1,
  parameter int AW    = 34,
  parameter int BW    = 34,
  parameter int SBW   = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sccol_pkg::pipe_ctl_t              ctl,
  input  logic [LANES-1:0][AW-1:0]          a,
  input  logic [LANES-1:0][BW-1:0]          b,
  input  logic [SBW-1:0]                    sb_in,
  output logic                              vld,
  output logic [LANES-1:0][AW+BW-1:0]       p,
  output logic [SBW-1:0]                    sb_out
);

  localparam int AL = AW / 2;
  localparam int BL = BW / 2;
  localparam int AH = AW - AL;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic           vld1;
  logic [SBW-1:0] sb1;

  // valid travels with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld  <= 1'b0;
    end else if (ctl.en) begin
      vld1 <= ctl.vld;
      vld  <= vld1;
    end
  end

  // sideband delay matching the product latency
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      sb1    <= sb_in;
      sb_out <= sb1;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [AH-1:0]      ah;
    logic signed [BH-1:0]      bh;
    logic signed [AL:0]        al;
    logic signed [BL:0]        bl;
    logic signed [AH+BH-1:0]   hh;
    logic signed [AH+BL:0]     hl;
    logic signed [AL+BH:0]     lh;
    logic        [AL+BL-1:0]   ll;
    logic signed [PW-1:0]      pp_hh, pp_hl, pp_lh, pp_ll;

    // split into signed high and unsigned low halves
    assign ah = $signed(a[i][AW-1:AL]);
    assign bh = $signed(b[i][BW-1:BL]);
    assign al = $signed({1'b0, a[i][AL-1:0]});
    assign bl = $signed({1'b0, b[i][BL-1:0]});
    assign hh = ah * bh;
    assign hl = ah * bl;
    assign lh = al * bh;
    assign ll = a[i][AL-1:0] * b[i][BL-1:0];

    // partial products, then the shifted sum
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        pp_hh <= PW'(hh);
        pp_hl <= PW'(hl);
        pp_lh <= PW'(lh);
        pp_ll <= $signed(PW'(ll));
        p[i]  <= (pp_hh <<< (AL + BL)) + (pp_hl <<< BL) + (pp_lh <<< AL) + pp_ll;
      end
    end
  end

endmodule

// ===== rtl/sccol_div.sv =====
// sccol_div: pipelined floor division of two numerators by one divisor
// one restoring quotient bit per stage, sign fix in the last stage
// depends on sccol_pkg (pipe_ctl_t)
module sccol_div #(
  parameter int NW   = 103,
  parameter int DENW = 69,
  parameter int QB   = 34,
  parameter int SBW  = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sccol_pkg::pipe_ctl_t     ctl,
  input  logic signed [NW-1:0]     num_x,
  input  logic signed [NW-1:0]     num_y,
  input  logic [DENW-1:0]          den,
  input  logic [SBW-1:0]           sb_in,
  output logic                     vld,
  output logic signed [QB:0]       quo_x,
  output logic signed [QB:0]       quo_y,
  output logic [SBW-1:0]           sb_out
);

  logic signed [NW-1:0] nums [2];
  logic [NW-1:0]        rem_s [2][QB+1];
  logic [QB-1:0]        q_s   [2][QB+1];
  logic [NW-1:0]        rem_n [2][QB];
  logic [QB-1:0]        q_n   [2][QB];
  logic [DENW-1:0]      d_s   [QB+1];
  logic [1:0]           neg_s [QB+1];
  logic [SBW-1:0]       sb_s  [QB+1];
  logic                 vld_s [QB+1];
  logic [QB:0]          qe    [2];
  logic signed [QB:0]   quo_r [2];

  assign nums[0] = num_x;
  assign nums[1] = num_y;

  // one compare and subtract per stage, divisor shifted to that bit
  always_comb begin
    logic [NW:0] dsh;
    logic [NW:0] diff;
    logic        take;
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < QB; k++) begin
        dsh  = (NW+1)'(d_s[k]) << (QB - 1 - k);
        diff = {1'b0, rem_s[j][k]} - dsh;
        take = !diff[NW];
        rem_n[j][k] = take ? diff[NW-1:0] : rem_s[j][k];
        q_n[j][k]   = q_s[j][k] | (take ? (QB'(1) << (QB - 1 - k)) : '0);
      end
      qe[j] = {1'b0, q_s[j][QB]} + (QB+1)'(rem_s[j][QB] != '0);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) vld_s[k] <= 1'b0;
      vld <= 1'b0;
    end else if (ctl.en) begin
      vld_s[0] <= ctl.vld;
      for (int k = 0; k < QB; k++) vld_s[k+1] <= vld_s[k];
      vld <= vld_s[QB];
    end
  end

  // magnitude in, quotient bits, rounding toward minus infinity out
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int j = 0; j < 2; j++) begin
        neg_s[0][j] <= nums[j][NW-1];
        rem_s[j][0] <= nums[j][NW-1] ? NW'(-nums[j]) : NW'(nums[j]);
        q_s[j][0]   <= '0;
        for (int k = 0; k < QB; k++) begin
          rem_s[j][k+1] <= rem_n[j][k];
          q_s[j][k+1]   <= q_n[j][k];
        end
        quo_r[j] <= neg_s[QB][j] ? $signed(-qe[j]) : $signed({1'b0, q_s[j][QB]});
      end
      d_s[0]  <= den;
      sb_s[0] <= sb_in;
      for (int k = 0; k < QB; k++) begin
        d_s[k+1]   <= d_s[k];
        neg_s[k+1] <= neg_s[k];
        sb_s[k+1]  <= sb_s[k];
      end
      sb_out <= sb_s[QB];
    end
  end

  assign quo_x = quo_r[0];
  assign quo_y = quo_r[1];

endmodule

// ===== tb/swept_circle_collision_test_checker.sv =====
// swept circle collision checker: watches both channels of the block
// predicts each result item from the accepted pair and compares field by field
// depends on sccol_pkg
`timescale 1ns / 1ps

module swept_circle_collision_test_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] first_x,
  input  logic signed [31:0] first_y,
  input  logic signed [31:0] first_vx,
  input  logic signed [31:0] first_vy,
  input  logic [30:0]        first_radius,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  input  logic signed [31:0] second_vx,
  input  logic signed [31:0] second_vy,
  input  logic [30:0]        second_radius,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               collided,
  input  logic signed [31:0] contact_x,
  input  logic signed [31:0] contact_y,
  input  logic [1:0]         cause,
  output int                 errors,
  output int                 pending
);

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    sccol_pkg::cause_t  why;
  } contact_t;

  contact_t contact_q[$];

  // quotient rounded toward minus infinity, divisor positive
  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if (n < 0 && q * d != n) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t v);
    wide_t lo, hi;
    lo = -64'sd2147483648;
    hi = 64'sd2147483647;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[31:0];
  endfunction

  // line of the mover passes strictly within the still circle
  function automatic logic line_hit(wide_t mx, wide_t my, wide_t dx, wide_t dy,
                                    wide_t ix, wide_t iy, wide_t r,
                                    output wide_t cx, output wide_t cy);
    wide_t wx, wy, dd, cr, dot;
    wx = ix - mx;
    wy = iy - my;
    dd = dx * dx + dy * dy;
    cr = dx * wy - dy * wx;
    cx = 0;
    cy = 0;
    if (cr * cr >= r * r * dd) return 1'b0;
    dot = dx * wx + dy * wy;
    cx = mx + floor_div(dot * dx, dd);
    cy = my + floor_div(dot * dy, dd);
    return 1'b1;
  endfunction

  // swept segments of two movers intersect or overlap collinearly
  function automatic logic paths_hit(wide_t p1x, wide_t p1y, wide_t v1x, wide_t v1y,
                                     wide_t p2x, wide_t p2y, wide_t v2x, wide_t v2y,
                                     output wide_t cx, output wide_t cy);
    wide_t ax, ay, qx, qy, ex, ey, den, tn, un, sc, sd, dd1, lo, hi;
    ax = p1x - v1x;
    ay = p1y - v1y;
    qx = p2x - v2x;
    qy = p2y - v2y;
    ex = qx - ax;
    ey = qy - ay;
    den = v1x * v2y - v1y * v2x;
    cx = 0;
    cy = 0;
    if (den == 0) begin
      if (v1x * ey - v1y * ex != 0) return 1'b0;
      sc = ex * v1x + ey * v1y;
      sd = sc + v2x * v1x + v2y * v1y;
      dd1 = v1x * v1x + v1y * v1y;
      lo = (sc < sd) ? sc : sd;
      hi = (sc < sd) ? sd : sc;
      if (lo < 0) lo = 0;
      if (hi > dd1) hi = dd1;
      if (lo > hi) return 1'b0;
      cx = floor_div(p1x + qx, 2);
      cy = floor_div(p1y + qy, 2);
      return 1'b1;
    end
    tn = ex * v2y - ey * v2x;
    un = ex * v1y - ey * v1x;
    if (den < 0) begin
      den = -den;
      tn = -tn;
      un = -un;
    end
    if (tn < 0 || tn > den) return 1'b0;
    if (un < 0 || un > den) return 1'b0;
    cx = ax + floor_div(tn * v1x, den);
    cy = ay + floor_div(tn * v1y, den);
    return 1'b1;
  endfunction

  function automatic contact_t pair_contact(wide_t p1x, wide_t p1y, wide_t v1x, wide_t v1y,
                                            wide_t r1, wide_t p2x, wide_t p2y,
                                            wide_t v2x, wide_t v2y, wide_t r2);
    contact_t res;
    wide_t dx, dy, rs, cx, cy;
    logic still1, still2;
    dx = p1x - p2x;
    dy = p1y - p2y;
    rs = r1 + r2;
    cx = 0;
    cy = 0;
    still1 = (v1x == 0 && v1y == 0);
    still2 = (v2x == 0 && v2y == 0);
    res.why = sccol_pkg::CAUSE_NONE;
    if (dx * dx + dy * dy < rs * rs) begin
      cx = floor_div(p1x + p2x, 2);
      cy = floor_div(p1y + p2y, 2);
      res.why = sccol_pkg::CAUSE_OVERLAP;
    end else if (still1 && still2) begin
      res.why = sccol_pkg::CAUSE_NONE;
    end else if (still1) begin
      if (line_hit(p2x, p2y, v2x, v2y, p1x, p1y, r1, cx, cy))
        res.why = sccol_pkg::CAUSE_SINGLE;
    end else if (still2) begin
      if (line_hit(p1x, p1y, v1x, v1y, p2x, p2y, r2, cx, cy))
        res.why = sccol_pkg::CAUSE_SINGLE;
    end else begin
      if (paths_hit(p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y, cx, cy))
        res.why = sccol_pkg::CAUSE_CROSS;
    end
    res.hit = (res.why != sccol_pkg::CAUSE_NONE);
    res.cx = res.hit ? clamp32(cx) : 32'sd0;
    res.cy = res.hit ? clamp32(cy) : 32'sd0;
    return res;
  endfunction

  assign pending = contact_q.size();

  // predict on each accepted pair, compare on each accepted result
  always @(posedge clk) begin
    contact_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (in_valid && !in_stall)
        contact_q.insert(contact_q.size(),
                         pair_contact(first_x, first_y, first_vx, first_vy,
                                      first_radius, second_x, second_y,
                                      second_vx, second_vy, second_radius));
      if (out_valid && !out_stall) begin
        if (contact_q.size() == 0) begin
          $display("%0t: result item with none expected", $time);
          errors <= errors + 1;
        end else begin
          want = contact_q.pop_front();
          if (collided !== want.hit || contact_x !== want.cx || contact_y !== want.cy ||
              cause !== want.why) begin
            $display("%0t: mismatch exp hit=%0b x=%0d y=%0d cause=%0d", $time,
                     want.hit, want.cx, want.cy, want.why);
            $display("%0t:          got hit=%0b x=%0d y=%0d cause=%0d", $time,
                     collided, contact_x, contact_y, cause);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// testbench top for swept_circle_collision_test: drives circle pair items
// directed cases then random pairs with random gaps and output stalls
// depends on sccol_pkg, the block and swept_circle_collision_test_checker
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 1930;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] first_x, first_y, first_vx, first_vy;
  logic [30:0]        first_radius;
  logic signed [31:0] second_x, second_y, second_vx, second_vy;
  logic [30:0]        second_radius;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               collided;
  logic signed [31:0] contact_x, contact_y;
  logic [1:0]         cause;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  logic               no_idle;

  swept_circle_collision_test u_top (.*);

  swept_circle_collision_test_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** swept_circle_collision_test: FAILED **");
      $finish;
    end
  end

  // output side stalls at random outside the quiet stretch
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 9);
  end

  // hand one pair to the block and wait until it is taken
  task automatic send_pair(int fx, int fy, int fvx, int fvy, int fr,
                           int sx, int sy, int svx, int svy, int sr);
    if (!no_idle && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    first_x <= fx;  first_y <= fy;  first_vx <= fvx;  first_vy <= fvy;
    first_radius <= fr[30:0];
    second_x <= sx; second_y <= sy; second_vx <= svx; second_vy <= svy;
    second_radius <= sr[30:0];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // signed value within +-2^s
  function automatic int spread(int s);
    return int'($urandom_range(0, 1 << (s + 1))) - (1 << s);
  endfunction

  task automatic random_pair();
    int mode, s, fx, fy, fvx, fvy, sx, sy, svx, svy, k, m;
    mode = $urandom_range(0, 9);
    s = $urandom_range(3, 28);
    if (mode < 2) begin
      send_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (mode == 9) begin
      // collinear paths with small integer steps
      fx = spread(12); fy = spread(12);
      fvx = spread(6); fvy = spread(6);
      k = spread(2); m = spread(2);
      if ($urandom_range(0, 3) == 0) m = 0;
      send_pair(fx, fy, fvx, fvy, 0, fx + k * fvx, fy + k * fvy, m * fvx, m * fvy,
                0);
    end else begin
      fvx = spread(s); fvy = spread(s);
      svx = spread(s); svy = spread(s);
      if ($urandom_range(0, 3) == 0) begin fvx = 0; fvy = 0; end
      else if ($urandom_range(0, 3) == 0) begin svx = 0; svy = 0; end
      send_pair(spread(s), spread(s), fvx, fvy, $urandom_range(0, 1 << (s - 2)),
                spread(s), spread(s), svx, svy, $urandom_range(0, 1 << (s - 2)));
    end
  endtask

  initial begin
    no_idle = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    {first_x, first_y, first_vx, first_vy, first_radius} = '0;
    {second_x, second_y, second_vx, second_vy, second_radius} = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: overlap, still apart, single mover hit, miss and grazing
    send_pair(0, 0, 0, 0, 5, 1, 1, 0, 0, 5);
    send_pair(0, 0, 0, 0, 1, 100, 100, 0, 0, 1);
    send_pair(0, 0, 0, 0, 3, 20, 1, 40, 0, 0);
    send_pair(0, 0, 0, 0, 3, 20, 3, 40, 0, 0);
    send_pair(20, 1, 40, 0, 0, 0, 0, 0, 0, 3);
    send_pair(20, 9, 40, 0, 0, 0, 0, 0, 0, 3);
    // two movers: crossing, crossing at an end, parallel, collinear cases
    send_pair(10, 10, 20, 20, 0, 10, -10, 20, -20, 0);
    send_pair(10, 0, 10, 0, 0, 10, 5, 0, 10, 0);
    send_pair(10, 0, 10, 0, 0, 5, 3, 10, 0, 0);
    send_pair(10, 0, 10, 0, 0, 5, 0, -10, 0, 0);
    send_pair(10, 0, 10, 0, 0, 20, 0, 10, 0, 0);
    send_pair(10, 0, 10, 0, 0, 15, 0, -10, 0, 0);
    send_pair(10, 0, 10, 0, 0, 40, 0, 10, 0, 0);
    send_pair(10, 10, 20, 20, 0, 100, -10, 20, -20, 0);
    // field extremes and wide paths that push the contact out of range
    send_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_pair(32'h7fffffff, 0, 32'h80000000, 0, 0, 32'h7fffffff, 10, 0, 20, 0);
    send_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 0,
              32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0);
    send_pair(32'h80000000, 32'h80000000, 0, 0, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    send_pair(32'h80000000, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000001,
              32'h80000000, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle <= (n >= 500 && n < 800);
      if (n == 1000) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      random_pair();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("** swept_circle_collision_test: PASSED **");
    end else begin
      $display("** swept_circle_collision_test: FAILED **");
    end
    $finish;
  end

endmodule
